// ===== hdl/mgc_pkg.sv =====
// Shared types and constants for the motorized gate controller.
`timescale 1ns / 1ps

package mgc_pkg;

    // Phase register, one-hot.
    typedef enum logic [4:0] {
        PH_CLOSED   = 5'b00001,
        PH_OPENING  = 5'b00010,
        PH_OPEN     = 5'b00100,
        PH_CLOSING  = 5'b01000,
        PH_SETTLING = 5'b10000
    } phase_t;

    // Codes reported on gate_phase.
    localparam logic [2:0] GP_CLOSED   = 3'd0;
    localparam logic [2:0] GP_OPENING  = 3'd1;
    localparam logic [2:0] GP_OPEN     = 3'd2;
    localparam logic [2:0] GP_CLOSING  = 3'd3;
    localparam logic [2:0] GP_SETTLING = 3'd4;

    // Codes reported on motor_drive.
    localparam logic [1:0] MD_STOP  = 2'd0;
    localparam logic [1:0] MD_OPEN  = 2'd1;
    localparam logic [1:0] MD_CLOSE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_OPEN_RUN    = 2'd0;
    localparam logic [1:0] REG_CLOSE_DELAY = 2'd1;
    localparam logic [1:0] REG_SETTLE      = 2'd2;
    localparam logic [1:0] REG_DUTY        = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] OPEN_RUN_RESET    = 16'd500;
    localparam logic [15:0] CLOSE_DELAY_RESET = 16'd300;
    localparam logic [7:0]  SETTLE_RESET      = 8'd10;
    localparam logic [7:0]  DUTY_RESET        = 8'd255;

    typedef struct packed {
        logic open_request;
        logic beam_blocked;
        logic reed_closed;
    } mgc_in_t;

    typedef struct packed {
        logic [1:0] motor_drive;
        logic [7:0] pwm_duty;
        logic [2:0] gate_phase;
        logic       obstructed;
        logic       opened_event;
        logic       visitor_event;
        logic       closed_event;
    } mgc_out_t;

    typedef struct packed {
        logic [15:0] open_run_ticks;
        logic [15:0] close_delay_ticks;
        logic [7:0]  settle_ticks;
        logic [7:0]  drive_duty;
    } mgc_cfg_t;

    // Control state apart from the tick counter.
    typedef struct packed {
        phase_t phase;
        logic   visitor_seen;
        logic   paused;
    } mgc_state_t;

endpackage

// ===== hdl/mgc_step.sv =====
// Next-state and result logic of the gate controller for one polling tick.
`timescale 1ns / 1ps

module mgc_step #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  mgc_pkg::mgc_state_t          state,
    input  logic [TICK_COUNT_WIDTH-1:0]  elapsed,
    input  mgc_pkg::mgc_in_t             word,
    input  mgc_pkg::mgc_cfg_t            cfg,
    output mgc_pkg::mgc_state_t          state_next,
    output logic [TICK_COUNT_WIDTH-1:0]  elapsed_next,
    output mgc_pkg::mgc_out_t            result
);
    import mgc_pkg::*;

    localparam int CmpW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

    logic [TICK_COUNT_WIDTH-1:0] elapsed_inc;
    logic [CmpW-1:0]             inc_ext;
    logic                        ev_open;
    logic                        ev_visit;
    logic                        ev_closed;
    logic [1:0]                  drive;

    // Saturating increment of the tick counter.
    assign elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;
    assign inc_ext     = CmpW'(elapsed_inc);

    always_comb
    begin
        state_next   = state;
        elapsed_next = elapsed;
        ev_open      = 1'b0;
        ev_visit     = 1'b0;
        ev_closed    = 1'b0;

        case (state.phase)
            PH_CLOSED:
            begin
                if (word.open_request)
                begin
                    state_next.phase        = PH_OPENING;
                    state_next.visitor_seen = 1'b0;
                    elapsed_next            = '0;
                end
            end
            PH_OPENING:
            begin
                elapsed_next = elapsed_inc;
                if (inc_ext >= CmpW'(cfg.open_run_ticks))
                begin
                    state_next.phase        = PH_OPEN;
                    state_next.visitor_seen = 1'b0;
                    elapsed_next            = '0;
                    ev_open                 = 1'b1;
                end
            end
            PH_OPEN:
            begin
                if (state.visitor_seen)
                begin
                    elapsed_next = elapsed_inc;
                    if (inc_ext >= CmpW'(cfg.close_delay_ticks))
                    begin
                        state_next.phase  = PH_CLOSING;
                        state_next.paused = 1'b0;
                    end
                end
            end
            PH_CLOSING:
            begin
                // A blocked beam holds the motor and masks the reed switch.
                if (word.beam_blocked)
                begin
                    state_next.paused = 1'b1;
                end
                else
                begin
                    state_next.paused = 1'b0;
                    if (word.reed_closed)
                    begin
                        state_next.phase = PH_SETTLING;
                        elapsed_next     = '0;
                    end
                end
            end
            PH_SETTLING:
            begin
                elapsed_next = elapsed_inc;
                if (inc_ext >= CmpW'(cfg.settle_ticks))
                begin
                    state_next.phase = PH_CLOSED;
                    ev_closed        = 1'b1;
                end
            end
            default:
            begin
                state_next.phase        = PH_CLOSED;
                state_next.visitor_seen = 1'b0;
                state_next.paused       = 1'b0;
                elapsed_next            = '0;
            end
        endcase

        // Visitor detection also applies on the tick the gate becomes open.
        if (state_next.phase == PH_OPEN && !state_next.visitor_seen && word.beam_blocked)
        begin
            state_next.visitor_seen = 1'b1;
            elapsed_next            = '0;
            ev_visit                = 1'b1;
        end
    end

    always_comb
    begin
        if (state_next.phase == PH_OPENING)
            drive = MD_OPEN;
        else if ((state_next.phase == PH_CLOSING && !state_next.paused)
                 || state_next.phase == PH_SETTLING)
            drive = MD_CLOSE;
        else
            drive = MD_STOP;
    end

    always_comb
    begin
        result.motor_drive   = drive;
        result.pwm_duty      = (drive != MD_STOP) ? cfg.drive_duty : 8'd0;
        result.obstructed    = (state_next.phase == PH_CLOSING) && state_next.paused;
        result.opened_event  = ev_open;
        result.visitor_event = ev_visit;
        result.closed_event  = ev_closed;
        case (state_next.phase)
            PH_CLOSED:   result.gate_phase = GP_CLOSED;
            PH_OPENING:  result.gate_phase = GP_OPENING;
            PH_OPEN:     result.gate_phase = GP_OPEN;
            PH_CLOSING:  result.gate_phase = GP_CLOSING;
            PH_SETTLING: result.gate_phase = GP_SETTLING;
            default:     result.gate_phase = GP_CLOSED;
        endcase
    end

endmodule

// ===== hdl/motorized_gate_controller_top.sv =====
// Top level of the motorized gate controller: state, configuration and result queue.
`timescale 1ns / 1ps

// Each request word is one polling tick carrying the open request, break-beam and
// reed-switch levels; each tick produces exactly one response word with the motor
// direction, PWM duty, gate phase, obstruction flag and the opened, visitor and
// closed events. A tick is handled in one pass through the step logic, which
// updates the phase, tick counter and flags, and the result goes into a
// two-word output queue. A new request word is taken every cycle while the
// queue has room, so the sustained rate is one word per clock, and a result is
// written into the queue when its request word is accepted.
// Configuration registers (index 0 open_run_ticks, 1 close_delay_ticks,
// 2 settle_ticks, 3 drive_duty) are written through cfg_we/cfg_index/cfg_data and
// should only be changed while no word is in flight. TICK_COUNT_WIDTH sets the
// width of the saturating tick counter; a phase whose configured length exceeds
// the counter range never ends.
module motorized_gate_controller_top #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mgc_pkg::mgc_in_t  req_word,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output mgc_pkg::mgc_out_t rsp_word,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import mgc_pkg::*;

    mgc_cfg_t                    cfg_reg;
    mgc_state_t                  state_reg;
    mgc_state_t                  state_next;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_reg;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_next;
    mgc_out_t                    step_result;

    // Two-entry result queue: head and tail slot plus a fill count.
    mgc_out_t   head_reg;
    mgc_out_t   head_next;
    mgc_out_t   tail_reg;
    mgc_out_t   tail_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    mgc_step #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_step (
        .state        (state_reg),
        .elapsed      (elapsed_reg),
        .word         (req_word),
        .cfg          (cfg_reg),
        .state_next   (state_next),
        .elapsed_next (elapsed_next),
        .result       (step_result)
    );

    assign req_ready = (count_reg != 2'd2);
    assign rsp_valid = (count_reg != 2'd0);
    assign rsp_word  = head_reg;
    assign push      = req_valid && req_ready;
    assign pop       = rsp_valid && rsp_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_run_ticks    <= OPEN_RUN_RESET;
            cfg_reg.close_delay_ticks <= CLOSE_DELAY_RESET;
            cfg_reg.settle_ticks      <= SETTLE_RESET;
            cfg_reg.drive_duty        <= DUTY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OPEN_RUN:    cfg_reg.open_run_ticks    <= cfg_data;
                REG_CLOSE_DELAY: cfg_reg.close_delay_ticks <= cfg_data;
                REG_SETTLE:      cfg_reg.settle_ticks      <= cfg_data[7:0];
                REG_DUTY:        cfg_reg.drive_duty        <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Gate state advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_CLOSED;
            state_reg.visitor_seen <= 1'b0;
            state_reg.paused       <= 1'b0;
            elapsed_reg            <= '0;
        end
        else if (push)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Queue bookkeeping. A push into a full queue cannot happen since
    // req_ready is low then.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
                head_next = step_result;
            else
                tail_next = step_result;
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push && pop)
        begin
            if (count_reg == 2'd1)
                head_next = step_result;
            else
                begin
                    head_next = tail_reg;
                    tail_next = step_result;
                end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("result queue did not grow on push");

    a_closed_phase: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.closed_event |-> rsp_word.gate_phase == GP_CLOSED
            && rsp_word.motor_drive == MD_STOP)
        else $error("closed event without closed, stopped gate");

    a_obstructed_stop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.obstructed |-> rsp_word.motor_drive == MD_STOP
            && rsp_word.gate_phase == GP_CLOSING)
        else $error("obstructed while motor runs or outside closing");

    a_duty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.motor_drive == MD_STOP |-> rsp_word.pwm_duty == 8'd0)
        else $error("duty applied while motor stopped");
`endif

endmodule
